// File: hdl/ecae_pkg.sv
// Package for the cover art extractor: result kinds, parse phases and limits.
// Used by every module of the block; depends on nothing.
package ecae_pkg;

	localparam int COUNT_BITS_DEFAULT = 27;
	localparam int LIMIT_BITS = 27;
	localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 27'd67108864;
	localparam logic [7:0] PICTURE_TYPE = 8'd6;
	localparam logic [31:0] MIN_PICTURE = 32'd32;
	localparam int QUEUE_DEPTH = 4;

	typedef enum logic [1:0] {
		KIND_PAYLOAD = 2'd0,
		KIND_OK      = 2'd1,
		KIND_FAIL    = 2'd2
	} kind_t;

	typedef enum logic [4:0] {
		PH_IDLE, PH_DONE, PH_ID3_HDR, PH_FLAC_MAGIC, PH_FR_HDR, PH_FR_SKIP,
		PH_A_ENC, PH_A_MIME, PH_A_PTYPE, PH_A_DESC, PH_A_PAY, PH_DRAIN,
		PH_FL_BHDR, PH_FL_SKIP, PH_FP_HEAD, PH_FP_MIME, PH_FP_DLEN,
		PH_FP_DESC, PH_FP_DATALEN, PH_FP_DATA
	} phase_t;

	// What the parser decided for one byte.
	typedef struct packed {
		logic       has_payload;
		logic [7:0] payload;
		logic [1:0] verdict;
	} step_t;

endpackage

// File: hdl/ecae_parser.sv
// Front part: accepts file bytes and runs the container parse, one byte a cycle
// if the queue has room. Depends on ecae_pkg. Queues a record per result byte.
module ecae_parser #(
	parameter int COUNT_BITS = ecae_pkg::COUNT_BITS_DEFAULT
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [7:0]                     data_byte,
	input  logic                           first_byte,
	input  logic                           file_end,
	input  logic [ecae_pkg::LIMIT_BITS-1:0] size_limit,
	input  logic                           q_full,
	output logic                           q_push,
	output ecae_pkg::step_t                q_data
);

	localparam logic [COUNT_BITS-1:0] CMASK = {COUNT_BITS{1'b1}};
	localparam logic [31:0] CMASK_W = 32'(CMASK);
	localparam int WB = COUNT_BITS + 2;

	ecae_pkg::phase_t phase_q;
	logic [COUNT_BITS-1:0] position_q, container_size_q, section_end_q;
	logic [31:0] gather_shift_q, field_length_q;
	logic [7:0] tag_version_q, text_encoding_q, block_type_q;
	logic [3:0] hdr_index_q;
	logic pair_parity_q, prev_zero_q, last_block_flag_q, payload_seen_q, apic_match_q;

	ecae_pkg::phase_t phase_d;
	logic [COUNT_BITS-1:0] position_d, container_size_d, section_end_d;
	logic [31:0] gather_shift_d, field_length_d;
	logic [7:0] tag_version_d, text_encoding_d, block_type_d;
	logic [3:0] hdr_index_d;
	logic pair_parity_d, prev_zero_d, last_block_flag_d, payload_seen_d, apic_match_d;
	logic [1:0] verdict;
	logic has_payload;
	logic [7:0] payload_val;

	logic [31:0] limit_now;
	logic [COUNT_BITS-1:0] pos_inc;
	logic [31:0] gs7, gs8;
	logic [7:0] magic_b;
	logic accept;

	assign in_ready = !q_full;
	assign accept = in_valid && in_ready;
	assign pos_inc = position_q + 1'b1;
	assign gs7 = {gather_shift_q[24:0], data_byte[6:0]};
	assign gs8 = {gather_shift_q[23:0], data_byte};

	always_comb begin
		if ({5'd0, size_limit} < CMASK_W)
			limit_now = {5'd0, size_limit};
		else
			limit_now = CMASK_W;
	end

	always_comb begin
		logic [3:0] i;
		logic [WB-1:0] wsum;
		logic [WB-1:0] wpos, wlen, wcs;
		logic [COUNT_BITS-1:0] room;
		phase_d = phase_q; position_d = position_q; container_size_d = container_size_q;
		section_end_d = section_end_q; gather_shift_d = gather_shift_q;
		field_length_d = field_length_q; tag_version_d = tag_version_q;
		text_encoding_d = text_encoding_q; block_type_d = block_type_q;
		hdr_index_d = hdr_index_q; pair_parity_d = pair_parity_q; prev_zero_d = prev_zero_q;
		last_block_flag_d = last_block_flag_q; payload_seen_d = payload_seen_q;
		apic_match_d = apic_match_q;
		verdict = 2'd0; has_payload = 1'b0; payload_val = 8'd0;
		magic_b = 8'd0;
		i = position_q[3:0];
		wsum = '0;
		wpos = {2'b00, position_q};
		wlen = '0;
		wcs = {2'b00, container_size_q};
		room = '0;
		if (first_byte) begin
			phase_d = ecae_pkg::PH_IDLE; position_d = '0; container_size_d = '0;
			section_end_d = '0; gather_shift_d = '0; field_length_d = '0;
			tag_version_d = '0; text_encoding_d = '0; block_type_d = '0; hdr_index_d = '0;
			pair_parity_d = 1'b0; prev_zero_d = 1'b0; last_block_flag_d = 1'b0;
			payload_seen_d = 1'b0; apic_match_d = 1'b0;
			if (data_byte == "I") begin
				phase_d = ecae_pkg::PH_ID3_HDR; position_d = {{(COUNT_BITS-1){1'b0}}, 1'b1};
			end else if (data_byte == "f") begin
				phase_d = ecae_pkg::PH_FLAC_MAGIC; position_d = {{(COUNT_BITS-1){1'b0}}, 1'b1};
			end else begin
				verdict = ecae_pkg::KIND_FAIL; phase_d = ecae_pkg::PH_DONE;
			end
		end else begin
			unique case (phase_q)
				ecae_pkg::PH_ID3_HDR: begin
					unique case (i)
						4'd1: magic_b = "D";
						4'd2: magic_b = "3";
						default: magic_b = data_byte;
					endcase
					if (i < 4'd3 && data_byte != magic_b) begin
						verdict = ecae_pkg::KIND_FAIL; phase_d = ecae_pkg::PH_DONE;
					end else begin
						if (i == 4'd3) tag_version_d = data_byte;
						if (i >= 4'd6) gather_shift_d = gs7;
						position_d = pos_inc;
						if (i == 4'd9) begin
							if (gs7 == 32'd0 || gs7 > limit_now) begin
								verdict = ecae_pkg::KIND_FAIL; phase_d = ecae_pkg::PH_DONE;
							end else begin
								container_size_d = gs7[COUNT_BITS-1:0];
								position_d = '0;
								// begin_frame with position 0
								if (gs7 < 32'd10) begin
									verdict = ecae_pkg::KIND_FAIL; phase_d = ecae_pkg::PH_DONE;
								end else begin
									phase_d = ecae_pkg::PH_FR_HDR; hdr_index_d = '0;
									apic_match_d = 1'b1; gather_shift_d = '0;
								end
							end
						end
					end
				end
				ecae_pkg::PH_FR_HDR: begin
					unique case (hdr_index_q[1:0])
						2'd0: magic_b = "A";
						2'd1: magic_b = "P";
						2'd2: magic_b = "I";
						default: magic_b = "C";
					endcase
					if (hdr_index_q == 4'd0 && data_byte == 8'd0) begin
						verdict = ecae_pkg::KIND_FAIL; phase_d = ecae_pkg::PH_DONE;
					end else begin
						if (hdr_index_q < 4'd4 && data_byte != magic_b) apic_match_d = 1'b0;
						if (hdr_index_q >= 4'd4 && hdr_index_q < 4'd8)
							gather_shift_d = (tag_version_q >= 8'd4) ? gs7 : gs8;
						position_d = pos_inc;
						hdr_index_d = hdr_index_q + 4'd1;
						if (hdr_index_q == 4'd9) begin
							field_length_d = gather_shift_q;
							room = container_size_q - pos_inc;
							if (gather_shift_q == 32'd0 ||
								{1'b0, gather_shift_q} > {{(33-COUNT_BITS){1'b0}}, room}) begin
								verdict = ecae_pkg::KIND_FAIL; phase_d = ecae_pkg::PH_DONE;
							end else begin
								section_end_d = pos_inc + gather_shift_q[COUNT_BITS-1:0];
								payload_seen_d = 1'b0;
								phase_d = apic_match_q ? ecae_pkg::PH_A_ENC : ecae_pkg::PH_FR_SKIP;
							end
						end
					end
				end
				ecae_pkg::PH_FR_SKIP: begin
					position_d = pos_inc;
					if (pos_inc == section_end_q) begin
						if (container_size_q - pos_inc < COUNT_BITS'(10)) begin
							verdict = ecae_pkg::KIND_FAIL; phase_d = ecae_pkg::PH_DONE;
						end else begin
							phase_d = ecae_pkg::PH_FR_HDR; hdr_index_d = '0;
							apic_match_d = 1'b1; gather_shift_d = '0;
						end
					end
				end
				ecae_pkg::PH_A_ENC, ecae_pkg::PH_A_MIME, ecae_pkg::PH_A_PTYPE,
				ecae_pkg::PH_A_DESC, ecae_pkg::PH_A_PAY: begin
					unique case (phase_q)
						ecae_pkg::PH_A_ENC: begin
							text_encoding_d = data_byte; phase_d = ecae_pkg::PH_A_MIME;
						end
						ecae_pkg::PH_A_MIME: begin
							if (data_byte == 8'd0) phase_d = ecae_pkg::PH_A_PTYPE;
						end
						ecae_pkg::PH_A_PTYPE: begin
							phase_d = ecae_pkg::PH_A_DESC; pair_parity_d = 1'b0;
						end
						ecae_pkg::PH_A_DESC: begin
							if (text_encoding_q == 8'd1 || text_encoding_q == 8'd2) begin
								if (!pair_parity_q) begin
									if (section_end_q - position_q == COUNT_BITS'(1)) begin
										has_payload = 1'b1; payload_val = data_byte;
										phase_d = ecae_pkg::PH_A_PAY;
									end else begin
										prev_zero_d = (data_byte == 8'd0); pair_parity_d = 1'b1;
									end
								end else begin
									if (prev_zero_q && data_byte == 8'd0)
										phase_d = ecae_pkg::PH_A_PAY;
									pair_parity_d = 1'b0;
								end
							end else if (data_byte == 8'd0) begin
								phase_d = ecae_pkg::PH_A_PAY;
							end
						end
						default: begin
							has_payload = 1'b1; payload_val = data_byte;
						end
					endcase
					if (has_payload) payload_seen_d = 1'b1;
					position_d = pos_inc;
					if (pos_inc == section_end_q) begin
						if (!(payload_seen_q || has_payload)) begin
							verdict = ecae_pkg::KIND_FAIL; phase_d = ecae_pkg::PH_DONE;
						end else if (pos_inc == container_size_q) begin
							verdict = ecae_pkg::KIND_OK; phase_d = ecae_pkg::PH_DONE;
						end else begin
							phase_d = ecae_pkg::PH_DRAIN;
						end
					end
				end
				ecae_pkg::PH_DRAIN: begin
					position_d = pos_inc;
					if (pos_inc == container_size_q) begin
						verdict = ecae_pkg::KIND_OK; phase_d = ecae_pkg::PH_DONE;
					end
				end
				ecae_pkg::PH_FLAC_MAGIC: begin
					unique case (i)
						4'd1: magic_b = "L";
						4'd2: magic_b = "a";
						4'd3: magic_b = "C";
						default: magic_b = "f";
					endcase
					if (i > 4'd3 || data_byte != magic_b) begin
						verdict = ecae_pkg::KIND_FAIL; phase_d = ecae_pkg::PH_DONE;
					end else begin
						position_d = pos_inc;
						if (i == 4'd3) begin
							phase_d = ecae_pkg::PH_FL_BHDR; gather_shift_d = '0; hdr_index_d = '0;
						end
					end
				end
				ecae_pkg::PH_FL_BHDR: begin
					hdr_index_d = hdr_index_q + 4'd1;
					if (hdr_index_q == 4'd0) begin
						last_block_flag_d = data_byte[7];
						block_type_d = {1'b0, data_byte[6:0]};
						gather_shift_d = '0;
					end else begin
						gather_shift_d = gs8;
					end
					if (hdr_index_q == 4'd3) begin
						hdr_index_d = '0;
						if (block_type_q == ecae_pkg::PICTURE_TYPE) begin
							if (gs8 < ecae_pkg::MIN_PICTURE || gs8 > limit_now) begin
								verdict = ecae_pkg::KIND_FAIL; phase_d = ecae_pkg::PH_DONE;
							end else begin
								container_size_d = gs8[COUNT_BITS-1:0];
								position_d = '0; gather_shift_d = '0;
								phase_d = ecae_pkg::PH_FP_HEAD;
							end
						end else if (last_block_flag_q) begin
							verdict = ecae_pkg::KIND_FAIL; phase_d = ecae_pkg::PH_DONE;
						end else if (gs8 != 32'd0) begin
							field_length_d = gs8; phase_d = ecae_pkg::PH_FL_SKIP;
						end
					end
				end
				ecae_pkg::PH_FL_SKIP: begin
					field_length_d = field_length_q - 32'd1;
					if (field_length_q == 32'd1) begin
						phase_d = ecae_pkg::PH_FL_BHDR; gather_shift_d = '0; hdr_index_d = '0;
					end
				end
				ecae_pkg::PH_FP_HEAD: begin
					if (i >= 4'd4) gather_shift_d = gs8;
					position_d = pos_inc;
					if (i == 4'd7) begin
						field_length_d = gs8;
						if ({1'b0, gs8} + 33'd12 > {{(33-COUNT_BITS){1'b0}}, container_size_q}) begin
							verdict = ecae_pkg::KIND_FAIL; phase_d = ecae_pkg::PH_DONE;
						end else begin
							section_end_d = gs8[COUNT_BITS-1:0] + COUNT_BITS'(8);
							gather_shift_d = '0; hdr_index_d = '0;
							phase_d = (gs8 == 32'd0) ? ecae_pkg::PH_FP_DLEN : ecae_pkg::PH_FP_MIME;
						end
					end
				end
				ecae_pkg::PH_FP_MIME, ecae_pkg::PH_FP_DESC: begin
					position_d = pos_inc;
					if (pos_inc == section_end_q) begin
						gather_shift_d = '0; hdr_index_d = '0;
						phase_d = (phase_q == ecae_pkg::PH_FP_MIME) ?
							ecae_pkg::PH_FP_DLEN : ecae_pkg::PH_FP_DATALEN;
					end
				end
				ecae_pkg::PH_FP_DLEN, ecae_pkg::PH_FP_DATALEN: begin
					gather_shift_d = gs8;
					position_d = pos_inc;
					hdr_index_d = hdr_index_q + 4'd1;
					if (hdr_index_q == 4'd3) begin
						field_length_d = gs8;
						wpos = {2'b00, pos_inc};
						if (phase_q == ecae_pkg::PH_FP_DLEN) begin
							// gs8 exceeds any container when it does not fit in WB-2 bits
							wlen = WB'(gs8[COUNT_BITS-1:0]);
							wsum = wpos + wlen + WB'(20);
							if (gs8 > CMASK_W || wsum > wcs) begin
								verdict = ecae_pkg::KIND_FAIL; phase_d = ecae_pkg::PH_DONE;
							end else begin
								section_end_d = pos_inc + gs8[COUNT_BITS-1:0] + COUNT_BITS'(16);
								phase_d = ecae_pkg::PH_FP_DESC;
							end
						end else begin
							wlen = WB'(gs8[COUNT_BITS-1:0]);
							wsum = wpos + wlen;
							if (gs8 == 32'd0 || gs8 > CMASK_W || wsum > wcs) begin
								verdict = ecae_pkg::KIND_FAIL; phase_d = ecae_pkg::PH_DONE;
							end else begin
								section_end_d = pos_inc + gs8[COUNT_BITS-1:0];
								phase_d = ecae_pkg::PH_FP_DATA;
							end
						end
					end
				end
				ecae_pkg::PH_FP_DATA: begin
					has_payload = 1'b1; payload_val = data_byte; payload_seen_d = 1'b1;
					position_d = pos_inc;
					if (pos_inc == section_end_q) begin
						if (pos_inc == container_size_q) begin
							verdict = ecae_pkg::KIND_OK; phase_d = ecae_pkg::PH_DONE;
						end else begin
							phase_d = ecae_pkg::PH_DRAIN;
						end
					end
				end
				default: ;
			endcase
		end
		if (file_end && verdict == 2'd0 && phase_d != ecae_pkg::PH_IDLE &&
			phase_d != ecae_pkg::PH_DONE) begin
			verdict = ecae_pkg::KIND_FAIL; phase_d = ecae_pkg::PH_DONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= ecae_pkg::PH_IDLE;
			position_q <= '0; container_size_q <= '0; section_end_q <= '0;
			gather_shift_q <= '0; field_length_q <= '0;
			tag_version_q <= '0; text_encoding_q <= '0; block_type_q <= '0;
			hdr_index_q <= '0; pair_parity_q <= 1'b0; prev_zero_q <= 1'b0;
			last_block_flag_q <= 1'b0; payload_seen_q <= 1'b0; apic_match_q <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_d;
			position_q <= position_d; container_size_q <= container_size_d;
			section_end_q <= section_end_d; gather_shift_q <= gather_shift_d;
			field_length_q <= field_length_d; tag_version_q <= tag_version_d;
			text_encoding_q <= text_encoding_d; block_type_q <= block_type_d;
			hdr_index_q <= hdr_index_d; pair_parity_q <= pair_parity_d;
			prev_zero_q <= prev_zero_d; last_block_flag_q <= last_block_flag_d;
			payload_seen_q <= payload_seen_d; apic_match_q <= apic_match_d;
		end
	end

	assign q_push = accept && (has_payload || verdict != 2'd0);
	assign q_data = '{has_payload: has_payload, payload: payload_val, verdict: verdict};

	property p_done_quiet;
		@(posedge clk) disable iff (!arst_n)
		(accept && !first_byte && phase_q == ecae_pkg::PH_DONE) |-> !q_push;
	endproperty
	a_done_quiet: assert property (p_done_quiet) else $error("result from finished parse");

	property p_no_push_full;
		@(posedge clk) disable iff (!arst_n) q_full |-> !q_push;
	endproperty
	a_no_push_full: assert property (p_no_push_full) else $error("push into full queue");

	property p_verdict_done;
		@(posedge clk) disable iff (!arst_n)
		(q_push && q_data.verdict != 2'd0) |=> phase_q == ecae_pkg::PH_DONE;
	endproperty
	a_verdict_done: assert property (p_verdict_done) else $error("verdict without finish");

endmodule

// File: hdl/ecae_emitter.sv
// Back part: a short queue of step records and the unit that expands each into
// one or two result items. Depends on ecae_pkg.
module ecae_emitter (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_push,
	input  ecae_pkg::step_t q_data,
	output logic            q_full,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [1:0]      kind,
	output logic [7:0]      payload_byte,
	output logic            run_end
);

	localparam int D = ecae_pkg::QUEUE_DEPTH;
	localparam int AW = $clog2(D);

	ecae_pkg::step_t mem_q [D];
	logic [AW-1:0] wr_q, rd_q;
	logic [AW:0] cnt_q;
	logic half_q; // payload half of a two-result record already sent
	ecae_pkg::step_t head;
	logic pop, out_take;

	assign head = mem_q[rd_q];
	assign q_full = (cnt_q == (AW+1)'(D));
	assign out_valid = (cnt_q != '0);
	assign out_take = out_valid && out_ready;

	always_comb begin
		if (head.has_payload && !half_q) begin
			kind = ecae_pkg::KIND_PAYLOAD;
			payload_byte = head.payload;
			run_end = (head.verdict == 2'd0);
		end else begin
			kind = head.verdict;
			payload_byte = 8'd0;
			run_end = 1'b1;
		end
	end

	assign pop = out_take && run_end;

	always_ff @(posedge clk) begin
		if (q_push) mem_q[wr_q] <= q_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0; rd_q <= '0; cnt_q <= '0; half_q <= 1'b0;
		end else begin
			if (q_push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(q_push) - (AW+1)'(pop);
			if (pop) half_q <= 1'b0;
			else if (out_take) half_q <= 1'b1;
		end
	end

	property p_cnt_bound;
		@(posedge clk) disable iff (!arst_n) cnt_q <= (AW+1)'(D);
	endproperty
	a_cnt_bound: assert property (p_cnt_bound) else $error("queue overflow");

	property p_half_status;
		@(posedge clk) disable iff (!arst_n) half_q |-> (out_valid && kind != ecae_pkg::KIND_PAYLOAD);
	endproperty
	a_half_status: assert property (p_half_status) else $error("second half not status");

	property p_pop_empty;
		@(posedge clk) disable iff (!arst_n) (cnt_q == '0) |-> !half_q;
	endproperty
	a_pop_empty: assert property (p_pop_empty) else $error("half flag on empty queue");

endmodule

// File: hdl/embedded_cover_art_extractor_core.sv
// Cover art extractor: one file byte per item in, picture payload and status out.
// Each result is registered in the queue before it reaches the output.
// Throughput: one byte per cycle while the queue is not full; a byte with payload
// and status yields two results; the four-entry queue absorbs output stalls.
// Reset: parse goes idle, size_limit returns to 64 MiB; the queue empties.
module embedded_cover_art_extractor_core #(
	parameter int COUNT_BITS = ecae_pkg::COUNT_BITS_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        first_byte,
	input  logic        file_end,
	input  logic        cfg_we,
	input  logic [26:0] cfg_wdata,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [7:0]  payload_byte,
	output logic        run_end
);

	logic [ecae_pkg::LIMIT_BITS-1:0] size_limit_q;
	logic q_full, q_push;
	ecae_pkg::step_t q_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) size_limit_q <= ecae_pkg::LIMIT_RESET;
		else if (cfg_we) size_limit_q <= cfg_wdata;
	end

	ecae_parser #(.COUNT_BITS(COUNT_BITS)) u_parser (
		.clk, .arst_n, .in_valid, .in_ready, .data_byte, .first_byte, .file_end,
		.size_limit(size_limit_q), .q_full, .q_push, .q_data
	);

	ecae_emitter u_emitter (
		.clk, .arst_n, .q_push, .q_data, .q_full,
		.out_valid, .out_ready, .kind, .payload_byte, .run_end
	);

endmodule

// File: test/embedded_cover_art_extractor_core_tb.sv
// Self-checking bench for the cover art extractor: builds ID3v2 and FLAC files,
// predicts payload and status per byte, and checks the output stream.
// Depends on ecae_pkg and embedded_cover_art_extractor_core.
module embedded_cover_art_extractor_core_tb;
	import ecae_pkg::*;

	localparam logic [31:0] CNT_MASK = 32'h7FFFFFF;

	typedef struct {
		logic [7:0] data;
		logic       first;
		logic       last;
	} file_item_t;

	typedef struct {
		kind_t      k;
		logic [7:0] p;
		logic       e;
	} art_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte = 8'd0;
	logic        first_byte = 1'b0;
	logic        file_end = 1'b0;
	logic        cfg_we = 1'b0;
	logic [26:0] cfg_wdata = 27'd0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  kind;
	logic [7:0]  payload_byte;
	logic        run_end;

	file_item_t  pending_bytes[$];
	art_result_t art_expected[$];
	logic [7:0]  fb[$];
	int          errors = 0;
	int          send_gap = 0;
	int          recv_stall = 0;

	// parser shadow state
	phase_t      ph = PH_IDLE;
	logic [31:0] pos, csize, send_pos, gsh, flen;
	logic [7:0]  tver, tenc, btype, hidx;
	logic        parity, pzero, lastblk, pseen, amatch;
	logic [26:0] lim = LIMIT_RESET;
	logic [1:0]  verdict;
	logic        has_pay;
	logic [7:0]  pay_val;

	embedded_cover_art_extractor_core DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.data_byte(data_byte), .first_byte(first_byte), .file_end(file_end),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.out_valid(out_valid), .out_ready(out_ready),
		.kind(kind), .payload_byte(payload_byte), .run_end(run_end)
	);

	always #5 clk = ~clk;

	task automatic clear_parse();
		ph = PH_IDLE; pos = 0; csize = 0; send_pos = 0; gsh = 0; flen = 0;
		tver = 0; tenc = 0; btype = 0; hidx = 0;
		parity = 0; pzero = 0; lastblk = 0; pseen = 0; amatch = 0;
	endtask

	task automatic conclude(input logic [1:0] v);
		verdict = v;
		ph = PH_DONE;
	endtask

	task automatic emit(input logic [7:0] b);
		has_pay = 1'b1;
		pay_val = b;
		pseen = 1'b1;
	endtask

	task automatic begin_frame();
		if (csize - pos < 32'd10) begin
			conclude(KIND_FAIL);
		end else begin
			ph = PH_FR_HDR; hidx = 0; amatch = 1'b1; gsh = 0;
		end
	endtask

	task automatic start_gather(input phase_t nxt);
		ph = nxt; gsh = 0; hidx = 0;
	endtask

	task automatic apic_advance();
		pos = (pos + 1) & CNT_MASK;
		if (pos == send_pos) begin
			if (!pseen) conclude(KIND_FAIL);
			else if (pos == csize) conclude(KIND_OK);
			else ph = PH_DRAIN;
		end
	endtask

	task automatic parse_byte(input logic [7:0] b);
		logic [7:0] i;
		logic [7:0] id3m[3];
		logic [7:0] apm[4];
		logic [7:0] flm[4];
		id3m = '{8'h49, 8'h44, 8'h33};
		apm = '{8'h41, 8'h50, 8'h49, 8'h43};
		flm = '{8'h66, 8'h4C, 8'h61, 8'h43};
		case (ph)
		PH_ID3_HDR: begin
			i = pos[7:0];
			if (i < 3 && b != id3m[i]) begin
				conclude(KIND_FAIL);
			end else begin
				if (i == 3) tver = b;
				if (i >= 6) gsh = (gsh << 7) | {25'd0, b[6:0]};
				pos++;
				if (i == 9) begin
					if (gsh == 0 || gsh > {5'd0, lim}) begin
						conclude(KIND_FAIL);
					end else begin
						csize = gsh; pos = 0;
						begin_frame();
					end
				end
			end
		end
		PH_FR_HDR: begin
			i = hidx;
			if (i == 0 && b == 0) begin
				conclude(KIND_FAIL);
			end else begin
				if (i < 4 && b != apm[i]) amatch = 1'b0;
				if (i >= 4 && i < 8) begin
					if (tver >= 4) gsh = (gsh << 7) | {25'd0, b[6:0]};
					else gsh = (gsh << 8) | {24'd0, b};
				end
				pos = (pos + 1) & CNT_MASK;
				hidx++;
				if (i == 9) begin
					flen = gsh;
					if (flen == 0 || flen > csize - pos) begin
						conclude(KIND_FAIL);
					end else begin
						send_pos = pos + flen;
						pseen = 1'b0;
						ph = amatch ? PH_A_ENC : PH_FR_SKIP;
					end
				end
			end
		end
		PH_FR_SKIP: begin
			pos = (pos + 1) & CNT_MASK;
			if (pos == send_pos) begin_frame();
		end
		PH_A_ENC: begin
			tenc = b; ph = PH_A_MIME;
			apic_advance();
		end
		PH_A_MIME: begin
			if (b == 0) ph = PH_A_PTYPE;
			apic_advance();
		end
		PH_A_PTYPE: begin
			ph = PH_A_DESC; parity = 1'b0;
			apic_advance();
		end
		PH_A_DESC: begin
			if (tenc == 1 || tenc == 2) begin
				if (!parity) begin
					if (send_pos - pos == 1) begin
						emit(b); ph = PH_A_PAY;
					end else begin
						pzero = (b == 0); parity = 1'b1;
					end
				end else begin
					if (pzero && b == 0) ph = PH_A_PAY;
					parity = 1'b0;
				end
			end else if (b == 0) begin
				ph = PH_A_PAY;
			end
			apic_advance();
		end
		PH_A_PAY: begin
			emit(b);
			apic_advance();
		end
		PH_DRAIN: begin
			pos = (pos + 1) & CNT_MASK;
			if (pos == csize) conclude(KIND_OK);
		end
		PH_FLAC_MAGIC: begin
			i = pos[7:0];
			if (i > 3 || b != flm[i[1:0]]) begin
				conclude(KIND_FAIL);
			end else begin
				pos++;
				if (i == 3) start_gather(PH_FL_BHDR);
			end
		end
		PH_FL_BHDR: begin
			i = hidx;
			if (i == 0) begin
				lastblk = b[7]; btype = {1'b0, b[6:0]}; gsh = 0;
			end else begin
				gsh = (gsh << 8) | {24'd0, b};
			end
			hidx++;
			if (i == 3) begin
				hidx = 0;
				if (btype == PICTURE_TYPE) begin
					if (gsh < MIN_PICTURE || gsh > {5'd0, lim}) begin
						conclude(KIND_FAIL);
					end else begin
						csize = gsh; pos = 0; gsh = 0; ph = PH_FP_HEAD;
					end
				end else if (lastblk) begin
					conclude(KIND_FAIL);
				end else if (gsh != 0) begin
					flen = gsh; ph = PH_FL_SKIP;
				end
			end
		end
		PH_FL_SKIP: begin
			flen--;
			if (flen == 0) start_gather(PH_FL_BHDR);
		end
		PH_FP_HEAD: begin
			i = pos[7:0];
			if (i >= 4) gsh = (gsh << 8) | {24'd0, b};
			pos++;
			if (i == 7) begin
				flen = gsh;
				if (64'd12 + {32'd0, flen} > {32'd0, csize}) begin
					conclude(KIND_FAIL);
				end else begin
					send_pos = 32'd8 + flen;
					start_gather(flen == 0 ? PH_FP_DLEN : PH_FP_MIME);
				end
			end
		end
		PH_FP_MIME, PH_FP_DESC: begin
			pos = (pos + 1) & CNT_MASK;
			if (pos == send_pos)
				start_gather(ph == PH_FP_MIME ? PH_FP_DLEN : PH_FP_DATALEN);
		end
		PH_FP_DLEN, PH_FP_DATALEN: begin
			gsh = (gsh << 8) | {24'd0, b};
			pos = (pos + 1) & CNT_MASK;
			hidx++;
			if (hidx == 4) begin
				flen = gsh;
				if (ph == PH_FP_DLEN) begin
					if ({32'd0, pos} + {32'd0, flen} + 64'd20 > {32'd0, csize}) begin
						conclude(KIND_FAIL);
					end else begin
						send_pos = pos + flen + 32'd16;
						ph = PH_FP_DESC;
					end
				end else if (flen == 0 ||
						{32'd0, pos} + {32'd0, flen} > {32'd0, csize}) begin
					conclude(KIND_FAIL);
				end else begin
					send_pos = pos + flen;
					ph = PH_FP_DATA;
				end
			end
		end
		PH_FP_DATA: begin
			emit(b);
			pos = (pos + 1) & CNT_MASK;
			if (pos == send_pos) begin
				if (pos == csize) conclude(KIND_OK);
				else ph = PH_DRAIN;
			end
		end
		default: ;
		endcase
	endtask

	task automatic predict_art(input file_item_t it);
		art_result_t r;
		verdict = 0; has_pay = 0; pay_val = 0;
		if (it.first) begin
			clear_parse();
			if (it.data == 8'h49) begin
				ph = PH_ID3_HDR; pos = 1;
			end else if (it.data == 8'h66) begin
				ph = PH_FLAC_MAGIC; pos = 1;
			end else begin
				conclude(KIND_FAIL);
			end
		end else if (ph != PH_IDLE && ph != PH_DONE) begin
			parse_byte(it.data);
		end
		if (it.last && verdict == 0 && ph != PH_IDLE && ph != PH_DONE)
			conclude(KIND_FAIL);
		if (has_pay) begin
			r.k = KIND_PAYLOAD; r.p = pay_val; r.e = (verdict == 0);
			art_expected.push_back(r);
		end
		if (verdict != 0) begin
			r.k = kind_t'(verdict); r.p = 8'd0; r.e = 1'b1;
			art_expected.push_back(r);
		end
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 94) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// driver: present the next item once the gap has run out
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			send_gap <= 0;
		end else begin
			if (in_valid && in_ready)
				predict_art('{data_byte, first_byte, file_end});
			if ((in_valid && in_ready) || !in_valid) begin
				if (send_gap == 0 && pending_bytes.size() > 0) begin
					data_byte <= pending_bytes[0].data;
					first_byte <= pending_bytes[0].first;
					file_end <= pending_bytes[0].last;
					void'(pending_bytes.pop_front());
					in_valid <= 1'b1;
					send_gap <= pick_gap();
				end else begin
					in_valid <= 1'b0;
					if (send_gap > 0) send_gap <= send_gap - 1;
				end
			end
		end
	end

	// monitor: random back-pressure and compare against the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			recv_stall <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (art_expected.size() == 0) begin
					$error("result with nothing expected: kind %0d byte %0h", kind, payload_byte);
					errors++;
				end else begin
					if (kind !== art_expected[0].k) begin
						$error("kind expected %0d actual %0d", art_expected[0].k, kind);
						errors++;
					end
					if (payload_byte !== art_expected[0].p) begin
						$error("payload_byte expected %0h actual %0h",
							art_expected[0].p, payload_byte);
						errors++;
					end
					if (run_end !== art_expected[0].e) begin
						$error("run_end expected %0d actual %0d", art_expected[0].e, run_end);
						errors++;
					end
					void'(art_expected.pop_front());
				end
			end
			if (recv_stall > 0) begin
				out_ready <= 1'b0;
				recv_stall <= recv_stall - 1;
			end else begin
				out_ready <= 1'b1;
				recv_stall <= pick_gap();
			end
		end
	end

	task automatic put32(input logic [31:0] v);
		fb.push_back(v[31:24]); fb.push_back(v[23:16]);
		fb.push_back(v[15:8]); fb.push_back(v[7:0]);
	endtask

	task automatic put_syncsafe(input logic [31:0] v);
		fb.push_back({1'b0, v[27:21]}); fb.push_back({1'b0, v[20:14]});
		fb.push_back({1'b0, v[13:7]}); fb.push_back({1'b0, v[6:0]});
	endtask

	task automatic put_rand(input int n, input bit nonzero);
		repeat (n) fb.push_back(nonzero ? 8'($urandom_range(1, 255)) : 8'($urandom));
	endtask

	// hand one built file to the driver, maybe damaged or cut short
	task automatic queue_file(input bit mangle);
		int n;
		file_item_t it;
		n = fb.size();
		if (mangle && $urandom_range(0, 99) < 12 && n > 1)
			fb[$urandom_range(1, n - 1)] = 8'($urandom);
		if (mangle && $urandom_range(0, 99) < 10) n = $urandom_range(1, n);
		for (int k = 0; k < n; k++) begin
			it.data = fb[k];
			it.first = (k == 0);
			it.last = (k == n - 1) && (!mangle || $urandom_range(0, 9) != 0);
			pending_bytes.push_back(it);
		end
		fb.delete();
	endtask

	task automatic build_id3(input int ver, input bit with_apic, input int enc,
			input int pay_len, input bit lone);
		logic [7:0] body[$];
		logic [7:0] fr[$];
		int nf;
		fb.delete();
		nf = $urandom_range(0, 2);
		for (int f = 0; f < nf + 1; f++) begin
			fr.delete();
			if (f == nf && with_apic) begin
				fr.push_back(8'(enc));
				repeat ($urandom_range(0, 5)) fr.push_back(8'($urandom_range(97, 122)));
				fr.push_back(8'd0);
				fr.push_back(8'($urandom));
				if (enc == 1 || enc == 2) begin
					repeat ($urandom_range(0, 3)) begin
						fr.push_back(8'($urandom_range(1, 255)));
						fr.push_back(8'($urandom));
					end
					if (lone) begin
						fr.push_back(8'($urandom));
					end else begin
						fr.push_back(8'd0); fr.push_back(8'd0);
					end
				end else begin
					repeat ($urandom_range(0, 4)) fr.push_back(8'($urandom_range(1, 255)));
					fr.push_back(8'd0);
				end
				repeat (lone ? 0 : pay_len) fr.push_back(8'($urandom));
				fb = '{8'h41, 8'h50, 8'h49, 8'h43};
			end else if (f < nf) begin
				repeat ($urandom_range(1, 8)) fr.push_back(8'($urandom));
				fb = '{8'($urandom_range(65, 90)), 8'($urandom_range(65, 90)),
					8'($urandom_range(48, 90)), 8'($urandom_range(48, 57))};
			end else begin
				continue;
			end
			if (ver >= 4) put_syncsafe(fr.size()); else put32(fr.size());
			fb.push_back(8'd0); fb.push_back(8'd0);
			body = {body, fb, fr};
			fb.delete();
		end
		// maybe a trailing frame, then padding
		if ($urandom_range(0, 3) == 0) begin
			body = {body, 8'h54, 8'h58, 8'h58, 8'h58, 8'd0, 8'd0, 8'd0, 8'd2, 8'd0, 8'd0,
				8'($urandom), 8'($urandom)};
		end
		repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 6) : 0) body.push_back(8'd0);
		fb = '{8'h49, 8'h44, 8'h33, 8'(ver), 8'd0, 8'd0};
		put_syncsafe(body.size());
		fb = {fb, body};
		put_rand($urandom_range(0, 5), 0);
	endtask

	task automatic build_flac(input bit with_pic, input int data_len);
		int nb;
		nb = $urandom_range(0, 2);
		// block headers: type byte then 24-bit length
		fb = '{8'h66, 8'h4C, 8'h61, 8'h43};
		repeat (nb) begin
			int bl;
			bl = $urandom_range(0, 6);
			fb.push_back(8'($urandom_range(0, 5)));
			fb.push_back(8'd0); fb.push_back(8'd0); fb.push_back(8'(bl));
			put_rand(bl, 0);
		end
		if (!with_pic) begin
			fb.push_back({1'b1, 7'($urandom_range(7, 126))});
			fb.push_back(8'd0); fb.push_back(8'd0); fb.push_back(8'd2);
			put_rand(2, 0);
		end else begin
			int ml, dl, xl;
			ml = $urandom_range(0, 5); dl = $urandom_range(0, 5); xl = $urandom_range(0, 3);
			fb.push_back({1'($urandom_range(0, 1)), 7'd6});
			// drop the top byte to leave a 24-bit length
			put32(32 + ml + dl + data_len + xl);
			fb.delete(fb.size() - 4);
			put32($urandom_range(0, 20));
			put32(ml); put_rand(ml, 0);
			put32(dl); put_rand(dl, 0);
			put_rand(16, 0);
			put32(data_len); put_rand(data_len, 0);
			put_rand(xl, 0);
		end
		put_rand($urandom_range(0, 4), 0);
	endtask

	task automatic random_file();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) begin
			build_id3($urandom_range(2, 4), $urandom_range(0, 9) != 0, $urandom_range(0, 3),
				$urandom_range(0, 19) == 0 ? $urandom_range(120, 160) :
				$urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 24),
				$urandom_range(0, 9) == 0);
		end else if (r < 90) begin
			build_flac($urandom_range(0, 9) != 0,
				$urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 30));
		end else begin
			fb.delete();
			fb.push_back($urandom_range(0, 2) == 0 ? 8'h49 : 8'($urandom));
			put_rand($urandom_range(0, 10), 0);
		end
		queue_file(1'b1);
	endtask

	task automatic settle();
		int guard;
		guard = 0;
		while ((pending_bytes.size() > 0 || in_valid || art_expected.size() > 0)
				&& guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (20) @(posedge clk);
	endtask

	task automatic write_limit(input logic [26:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		lim = v;
		@(posedge clk);
	endtask

	initial begin
		logic [26:0] limits[7];
		int sent;
		int base;
		limits = '{LIMIT_RESET, 27'd32, 27'h7FFFFFF, 27'd20, 27'd60, 27'd150, 27'd0};
		clear_parse();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// short directed files: bad magic, lone UTF-16 byte, empty payload, zero tag size
		fb = '{8'h58, 8'h00}; queue_file(1'b0);
		fb = '{8'h66, 8'h4C, 8'h41}; queue_file(1'b0);
		build_id3(3, 1'b1, 1, 0, 1'b1); queue_file(1'b0);
		build_flac(1'b1, 0); queue_file(1'b0);
		fb = '{8'h49, 8'h44, 8'h33, 8'd4, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
		queue_file(1'b0);
		for (int p = 0; p < 7; p++) begin
			if (p > 0) begin
				settle();
				write_limit(p == 6 ? 27'($urandom_range(32, 400)) : limits[p]);
			end
			sent = 0;
			while (sent < 245) begin
				base = pending_bytes.size();
				random_file();
				sent += pending_bytes.size() - base;
			end
		end
		settle();
		if (errors == 0 && art_expected.size() == 0 && pending_bytes.size() == 0) begin
			$display("simulation ok");
		end else begin
			if (art_expected.size() > 0)
				$error("%0d expected results never arrived", art_expected.size());
			$display("simulation failed");
		end
		$finish;
	end

	initial begin
		#20000000;
		$display("simulation failed");
		$finish;
	end

endmodule
